// ===== design/assert_macros.svh =====
// Assertion helpers; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== design/tpi_pkg.sv =====
`default_nettype none
package tpi_pkg;

	localparam int DEF_BUFFER_DEPTH = 8;
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [31:0] HALF_RANGE = 32'h80000000;

	typedef struct packed {
		logic               command;
		logic               frame_valid;
		logic               continuous;
		logic [31:0]        frame_id;
		logic [15:0]        grid_size;
		logic [47:0]        sim_time;
		logic [47:0]        receive_time;
		logic [47:0]        now_time;
		logic signed [31:0] playout_delay;
		logic signed [31:0] wind_x;
		logic signed [31:0] wind_y;
		logic signed [31:0] wind_z;
	} req_t;

	typedef struct packed {
		logic               accepted;
		logic [31:0]        prev_frame_id;
		logic [31:0]        next_frame_id;
		logic [16:0]        blend;
		logic [47:0]        interp_sim_time;
		logic signed [63:0] disp_x;
		logic signed [63:0] disp_y;
		logic signed [63:0] disp_z;
	} rsp_t;

	typedef struct packed {
		logic [31:0] frame_id;
		logic [15:0] grid_size;
		logic [47:0] sim_time;
		logic [47:0] receive_time;
	} slot_t;

	typedef logic [4:0] op_t;
	localparam op_t OP_NONE     = 5'd0;
	localparam op_t OP_PREJ     = 5'd1;
	localparam op_t OP_PRD_NEW  = 5'd2;
	localparam op_t OP_PCHK     = 5'd3;
	localparam op_t OP_PDROP    = 5'd4;
	localparam op_t OP_PWR      = 5'd5;
	localparam op_t OP_SEMPTY   = 5'd6;
	localparam op_t OP_STGT     = 5'd7;
	localparam op_t OP_SPREV    = 5'd8;
	localparam op_t OP_WADV     = 5'd9;
	localparam op_t OP_UPSET    = 5'd10;
	localparam op_t OP_NOUP     = 5'd11;
	localparam op_t OP_UADV     = 5'd12;
	localparam op_t OP_DIVINIT  = 5'd13;
	localparam op_t OP_DIVSTEP  = 5'd14;
	localparam op_t OP_IMUL     = 5'd15;
	localparam op_t OP_INTERP   = 5'd16;
	localparam op_t OP_WSTART   = 5'd17;
	localparam op_t OP_WHI      = 5'd18;
	localparam op_t OP_WLO      = 5'd19;
	localparam op_t OP_WINC     = 5'd20;
	localparam op_t OP_WCOM     = 5'd21;
	localparam op_t OP_SFIN     = 5'd22;

	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	typedef struct packed {
		logic  load;
		logic  emit;
		op_t   op;
		axis_t axis;
	} cmd_t;

	typedef struct packed {
		logic is_sample;
		logic frame_valid;
		logic count_zero;
		logic full;
		logic lo_last;
		logic walk_adv;
		logic has_next2;
		logic has_up;
		logic up_same;
		logic up_next2;
		logic div_needed;
		logic wind_go;
	} sts_t;

endpackage
`default_nettype wire

// ===== design/tpi_chan.sv =====
`default_nettype none
interface tpi_chan #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/timestamp_playout_interpolator.sv =====
// Playout interpolator for timestamped frames.
// req carries one item per handshake: command 0 pushes a frame stamp into an
// eight-deep (BUFFER_DEPTH) ring, command 1 asks for a playback sample. rsp
// returns exactly one item per request: push status, or the bracketing frame
// ids, the Q1.16 blend, the interpolated simulation time and the integrated
// wind displacement.
// A push may drop the oldest frame to make room. A sample with frames checks
// slots one at a time in the lower and upper walks (the slot memory read is
// registered), runs the bit-serial blend division when an upper frame exists
// and the blend falls below one, and adds wind integration when it applies.
// One item is worked on at a time; req.ready is high only while idle, so the
// next item is taken the cycle after a result is emitted.
// Reset empties the ring, clears the target and wind baseline and zeroes the
// displacement; no clearing pass is needed.
// A finished result sits in the rsp register; a new item is taken while it
// waits, but the next result holds in the controller until rsp drains.
`default_nettype none
`include "assert_macros.svh"
module timestamp_playout_interpolator #(
	parameter int BUFFER_DEPTH = tpi_pkg::DEF_BUFFER_DEPTH
) (
	input logic   clk,
	input logic   arst_n,
	tpi_chan.sink   req,
	tpi_chan.source rsp
);
	tpi_pkg::cmd_t cmd;
	tpi_pkg::sts_t sts;
	tpi_pkg::rsp_t res;
	tpi_pkg::rsp_t rsp_data_q;
	logic          rsp_valid_q;
	logic          out_free;
	logic          ready;

	// output slot is free when empty or draining this cycle
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = ready;

	tpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.out_free  (out_free),
		.sts       (sts),
		.cmd       (cmd)
	);

	tpi_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req.data),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	// result register: load on emit, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_data_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	`ASSERT_IMPLY(a_emit_needs_room, cmd.emit, (!rsp_valid_q || rsp.ready))
	`ASSERT_NEXT(a_busy_after_accept, (req.valid && req.ready), !req.ready)
	`ASSERT_IMPLY(a_rsp_from_emit, $rose(rsp_valid_q), $past(cmd.emit))
endmodule
`default_nettype wire

// ===== design/tpi_dp.sv =====
`default_nettype none
module tpi_dp #(
	parameter int BUFFER_DEPTH = tpi_pkg::DEF_BUFFER_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tpi_pkg::req_t item,
	input  tpi_pkg::cmd_t cmd,
	output tpi_pkg::sts_t sts,
	output tpi_pkg::rsp_t res
);
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int IW = CW + 1;
	localparam logic [IW-1:0] DEPTH_I = IW'(BUFFER_DEPTH);

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
			input logic [IW-1:0] i);
		logic [IW:0] s;
		s = {{(IW + 1 - AW){1'b0}}, base} + {1'b0, i};
		if (s >= {1'b0, DEPTH_I}) begin
			s = s - {1'b0, DEPTH_I};
		end
		return s[AW-1:0];
	endfunction

	// ring storage and read port
	tpi_pkg::slot_t mem [BUFFER_DEPTH];
	tpi_pkg::slot_t rd_q, prev_q, next_q, wr_data;
	logic [AW-1:0]  rd_addr, wr_addr;
	logic           rd_en, wr_en;

	// stream state
	logic [AW-1:0]      oldest_q;
	logic [CW-1:0]      count_q;
	logic               held_q, base_q;
	logic [47:0]        target_q, last_sim_q;
	logic signed [31:0] lw_x_q, lw_y_q, lw_z_q;
	logic signed [63:0] acc_x_q, acc_y_q, acc_z_q;

	// working registers
	tpi_pkg::req_t      item_q;
	tpi_pkg::rsp_t      res_q;
	logic [CW-1:0]      lo_q, up_q;
	logic [16:0]        blend_q;
	logic [47:0]        rem_q, interp_q;
	logic [63:0]        prod_q;
	logic               neg_q, ok_q;
	logic [56:0]        hi_q, lop_q;
	logic signed [63:0] inc_x_q, inc_y_q, inc_z_q;

	logic [IW-1:0] cnt_i, lo_i, up_i;
	logic [31:0]   id_delta;
	logic          cont_ok;
	logic [47:0]   delay_mag, req_time, tgt;
	logic [47:0]   iv, num, diff, dt;
	logic [48:0]   sh;
	logic          ge;
	logic signed [31:0] lw_sel, w_sel;
	logic signed [32:0] wsum;
	logic [32:0]   wabs;
	logic [23:0]   mul_b;
	logic [56:0]   wprod;
	logic [63:0]   mag;
	logic signed [63:0] inc_new;
	logic signed [64:0] sum_x, sum_y, sum_z;
	logic          ovf;

	assign cnt_i = IW'(count_q);
	assign lo_i  = IW'(lo_q);
	assign up_i  = IW'(up_q);

	// continuity against the newest stored frame
	assign id_delta = item_q.frame_id - rd_q.frame_id;
	always_comb begin
		if (count_q == '0) begin
			cont_ok = item_q.continuous;
		end else begin
			cont_ok = item_q.continuous && (item_q.grid_size == rd_q.grid_size) &&
				(item_q.sim_time > rd_q.sim_time) &&
				(item_q.receive_time >= rd_q.receive_time) &&
				(id_delta != '0) && (id_delta < tpi_pkg::HALF_RANGE);
		end
	end

	// playback target, never moving back
	assign delay_mag = item_q.playout_delay[31] ? '0 : {16'd0, item_q.playout_delay};
	assign req_time  = (item_q.now_time >= delay_mag) ? item_q.now_time - delay_mag : '0;
	assign tgt       = (held_q && target_q > req_time) ? target_q : req_time;

	assign iv   = next_q.receive_time - prev_q.receive_time;
	assign num  = target_q - prev_q.receive_time;
	assign diff = (next_q.sim_time >= prev_q.sim_time) ? next_q.sim_time - prev_q.sim_time
		: prev_q.sim_time - next_q.sim_time;
	assign sh   = {rem_q, 1'b0};
	assign ge   = sh >= {1'b0, iv};
	assign dt   = interp_q - last_sim_q;

	always_comb begin
		unique case (cmd.axis)
			tpi_pkg::AXIS_X: begin lw_sel = lw_x_q; w_sel = item_q.wind_x; end
			tpi_pkg::AXIS_Y: begin lw_sel = lw_y_q; w_sel = item_q.wind_y; end
			default:         begin lw_sel = lw_z_q; w_sel = item_q.wind_z; end
		endcase
	end

	assign wsum  = {lw_sel[31], lw_sel} + {w_sel[31], w_sel};
	assign wabs  = wsum[32] ? 33'(-wsum) : 33'(wsum);
	assign mul_b = (cmd.op == tpi_pkg::OP_WHI) ? dt[47:24] : dt[23:0];
	assign wprod = 57'(wabs) * 57'(mul_b);
	assign mag   = {1'b0, hi_q[55:0], 7'd0} + {24'd0, lop_q[56:17]};
	assign inc_new = wsum[32] ? -$signed(mag) : $signed(mag);

	assign sum_x = {acc_x_q[63], acc_x_q} + {inc_x_q[63], inc_x_q};
	assign sum_y = {acc_y_q[63], acc_y_q} + {inc_y_q[63], inc_y_q};
	assign sum_z = {acc_z_q[63], acc_z_q} + {inc_z_q[63], inc_z_q};
	assign ovf   = (sum_x[64] != sum_x[63]) || (sum_y[64] != sum_y[63]) ||
		(sum_z[64] != sum_z[63]);

	// status to the controller
	always_comb begin
		sts.is_sample   = item_q.command;
		sts.frame_valid = item_q.frame_valid;
		sts.count_zero  = count_q == '0;
		sts.full        = cnt_i == DEPTH_I;
		sts.lo_last     = (lo_i + IW'(1)) >= cnt_i;
		sts.walk_adv    = (rd_q.receive_time <= target_q) ||
			(rd_q.receive_time == prev_q.receive_time);
		sts.has_next2   = (lo_i + IW'(2)) < cnt_i;
		sts.has_up      = ((lo_i + IW'(1)) < cnt_i) && (target_q > prev_q.receive_time);
		sts.up_same     = rd_q.receive_time == next_q.receive_time;
		sts.up_next2    = (up_i + IW'(2)) < cnt_i;
		sts.div_needed  = (next_q.receive_time > prev_q.receive_time) && (num < iv);
		sts.wind_go     = base_q && (interp_q > last_sim_q);
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = slot_of(oldest_q, lo_i + IW'(1));
		wr_en   = cmd.op == tpi_pkg::OP_PWR;
		wr_addr = slot_of(oldest_q, cnt_i);
		wr_data = '{frame_id: item_q.frame_id, grid_size: item_q.grid_size,
			sim_time: item_q.sim_time, receive_time: item_q.receive_time};
		unique case (cmd.op)
			tpi_pkg::OP_PRD_NEW: begin
				rd_en   = count_q != '0;
				rd_addr = slot_of(oldest_q, cnt_i - IW'(1));
			end
			tpi_pkg::OP_PCHK: begin
				rd_en   = 1'b1;
				rd_addr = slot_of(oldest_q, IW'(1));
			end
			tpi_pkg::OP_STGT: begin
				rd_en   = 1'b1;
				rd_addr = oldest_q;
			end
			tpi_pkg::OP_SPREV: begin
				rd_en   = (lo_i + IW'(1)) < cnt_i;
			end
			tpi_pkg::OP_WADV, tpi_pkg::OP_UPSET: begin
				rd_en   = sts.has_next2;
				rd_addr = slot_of(oldest_q, lo_i + IW'(2));
			end
			tpi_pkg::OP_UADV: begin
				rd_en   = sts.up_next2;
				rd_addr = slot_of(oldest_q, up_i + IW'(2));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q   <= '0;
			count_q    <= '0;
			held_q     <= 1'b0;
			base_q     <= 1'b0;
			target_q   <= '0;
			last_sim_q <= '0;
			lw_x_q     <= '0;
			lw_y_q     <= '0;
			lw_z_q     <= '0;
			acc_x_q    <= '0;
			acc_y_q    <= '0;
			acc_z_q    <= '0;
		end else begin
			unique case (cmd.op)
				tpi_pkg::OP_PCHK: begin
					if (!cont_ok) begin
						count_q  <= '0;
						oldest_q <= '0;
						held_q   <= 1'b0;
						base_q   <= 1'b0;
						lw_x_q   <= '0;
						lw_y_q   <= '0;
						lw_z_q   <= '0;
					end
				end
				tpi_pkg::OP_PDROP: begin
					if (held_q && target_q < rd_q.receive_time) begin
						base_q <= 1'b0;
					end
					oldest_q <= slot_of(oldest_q, IW'(1));
					count_q  <= CW'(BUFFER_DEPTH - 1);
				end
				tpi_pkg::OP_PWR: begin
					count_q <= count_q + CW'(1);
				end
				tpi_pkg::OP_STGT: begin
					target_q <= tgt;
					held_q   <= 1'b1;
				end
				tpi_pkg::OP_WCOM: begin
					if (ok_q && !ovf) begin
						acc_x_q <= sum_x[63:0];
						acc_y_q <= sum_y[63:0];
						acc_z_q <= sum_z[63:0];
					end
				end
				tpi_pkg::OP_SFIN: begin
					last_sim_q <= interp_q;
					lw_x_q     <= item_q.wind_x;
					lw_y_q     <= item_q.wind_y;
					lw_z_q     <= item_q.wind_z;
					base_q     <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		unique case (cmd.op)
			tpi_pkg::OP_PREJ: res_q <= '0;
			tpi_pkg::OP_PWR: begin
				res_q <= {1'b1, {($bits(tpi_pkg::rsp_t) - 1){1'b0}}};
			end
			tpi_pkg::OP_SEMPTY: begin
				res_q <= {1'b0, 32'd0, 32'd0, 17'd0, 48'd0, acc_x_q, acc_y_q, acc_z_q};
			end
			tpi_pkg::OP_STGT: lo_q <= '0;
			tpi_pkg::OP_SPREV: prev_q <= rd_q;
			tpi_pkg::OP_WADV: begin
				lo_q   <= lo_q + CW'(1);
				prev_q <= rd_q;
			end
			tpi_pkg::OP_UPSET: begin
				next_q <= rd_q;
				up_q   <= lo_q + CW'(1);
			end
			tpi_pkg::OP_NOUP: begin
				next_q  <= prev_q;
				blend_q <= '0;
			end
			tpi_pkg::OP_UADV: begin
				next_q <= rd_q;
				up_q   <= up_q + CW'(1);
			end
			tpi_pkg::OP_DIVINIT: begin
				rem_q <= num;
				if ((next_q.receive_time > prev_q.receive_time) && (num >= iv)) begin
					blend_q <= tpi_pkg::ONE_Q16;
				end else begin
					blend_q <= '0;
				end
			end
			tpi_pkg::OP_DIVSTEP: begin
				rem_q   <= ge ? 48'(sh - {1'b0, iv}) : sh[47:0];
				blend_q <= {1'b0, blend_q[14:0], ge};
			end
			tpi_pkg::OP_IMUL: begin
				prod_q <= 64'(diff) * 64'(blend_q[15:0]);
				neg_q  <= next_q.sim_time < prev_q.sim_time;
			end
			tpi_pkg::OP_INTERP: begin
				if (blend_q[16]) begin
					interp_q <= next_q.sim_time;
				end else if (neg_q) begin
					interp_q <= prev_q.sim_time - prod_q[63:16];
				end else begin
					interp_q <= prev_q.sim_time + prod_q[63:16];
				end
			end
			tpi_pkg::OP_WSTART: ok_q <= 1'b1;
			tpi_pkg::OP_WHI: hi_q <= wprod;
			tpi_pkg::OP_WLO: lop_q <= wprod;
			tpi_pkg::OP_WINC: begin
				ok_q <= ok_q && !hi_q[56] && !mag[63];
				unique case (cmd.axis)
					tpi_pkg::AXIS_X: inc_x_q <= inc_new;
					tpi_pkg::AXIS_Y: inc_y_q <= inc_new;
					default:         inc_z_q <= inc_new;
				endcase
			end
			tpi_pkg::OP_SFIN: begin
				res_q.accepted        <= 1'b1;
				res_q.prev_frame_id   <= prev_q.frame_id;
				res_q.next_frame_id   <= next_q.frame_id;
				res_q.blend           <= blend_q;
				res_q.interp_sim_time <= interp_q;
				res_q.disp_x          <= acc_x_q;
				res_q.disp_y          <= acc_y_q;
				res_q.disp_z          <= acc_z_q;
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;
endmodule
`default_nettype wire

// ===== design/tpi_ctrl.sv =====
`default_nettype none
module tpi_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic          out_free,
	input  tpi_pkg::sts_t sts,
	output tpi_pkg::cmd_t cmd
);
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_DISP  = 5'd1;
	localparam logic [4:0] ST_PCHK  = 5'd2;
	localparam logic [4:0] ST_PDEC  = 5'd3;
	localparam logic [4:0] ST_PWR   = 5'd4;
	localparam logic [4:0] ST_SW0   = 5'd5;
	localparam logic [4:0] ST_SWCHK = 5'd6;
	localparam logic [4:0] ST_SBR   = 5'd7;
	localparam logic [4:0] ST_SUCHK = 5'd8;
	localparam logic [4:0] ST_SDIV0 = 5'd9;
	localparam logic [4:0] ST_SDIV  = 5'd10;
	localparam logic [4:0] ST_SMUL  = 5'd11;
	localparam logic [4:0] ST_SINT  = 5'd12;
	localparam logic [4:0] ST_SWND  = 5'd13;
	localparam logic [4:0] ST_SWHI  = 5'd14;
	localparam logic [4:0] ST_SWLO  = 5'd15;
	localparam logic [4:0] ST_SWINC = 5'd16;
	localparam logic [4:0] ST_SWCOM = 5'd17;
	localparam logic [4:0] ST_SFIN  = 5'd18;
	localparam logic [4:0] ST_EMIT  = 5'd19;

	localparam logic [3:0] DIV_LAST  = 4'd15;
	localparam logic [3:0] AXIS_LAST = 4'd2;

	logic [4:0] state_q, state_d;
	logic [3:0] cnt_q, cnt_d;

	assign req_ready = state_q == ST_IDLE;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.axis = cnt_q[1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				if (sts.is_sample) begin
					if (sts.count_zero) begin
						cmd.op  = tpi_pkg::OP_SEMPTY;
						state_d = ST_EMIT;
					end else begin
						cmd.op  = tpi_pkg::OP_STGT;
						state_d = ST_SW0;
					end
				end else if (!sts.frame_valid) begin
					cmd.op  = tpi_pkg::OP_PREJ;
					state_d = ST_EMIT;
				end else begin
					cmd.op  = tpi_pkg::OP_PRD_NEW;
					state_d = ST_PCHK;
				end
			end
			ST_PCHK: begin
				cmd.op  = tpi_pkg::OP_PCHK;
				state_d = ST_PDEC;
			end
			ST_PDEC: begin
				if (sts.full) begin
					cmd.op  = tpi_pkg::OP_PDROP;
					state_d = ST_PWR;
				end else begin
					cmd.op  = tpi_pkg::OP_PWR;
					state_d = ST_EMIT;
				end
			end
			ST_PWR: begin
				cmd.op  = tpi_pkg::OP_PWR;
				state_d = ST_EMIT;
			end
			ST_SW0: begin
				cmd.op  = tpi_pkg::OP_SPREV;
				state_d = sts.lo_last ? ST_SBR : ST_SWCHK;
			end
			ST_SWCHK: begin
				if (sts.walk_adv) begin
					cmd.op  = tpi_pkg::OP_WADV;
					state_d = sts.has_next2 ? ST_SWCHK : ST_SBR;
				end else begin
					state_d = ST_SBR;
				end
			end
			ST_SBR: begin
				if (sts.has_up) begin
					cmd.op  = tpi_pkg::OP_UPSET;
					state_d = sts.has_next2 ? ST_SUCHK : ST_SDIV0;
				end else begin
					cmd.op  = tpi_pkg::OP_NOUP;
					state_d = ST_SMUL;
				end
			end
			ST_SUCHK: begin
				if (sts.up_same) begin
					cmd.op  = tpi_pkg::OP_UADV;
					state_d = sts.up_next2 ? ST_SUCHK : ST_SDIV0;
				end else begin
					state_d = ST_SDIV0;
				end
			end
			ST_SDIV0: begin
				cmd.op = tpi_pkg::OP_DIVINIT;
				cnt_d  = '0;
				state_d = sts.div_needed ? ST_SDIV : ST_SMUL;
			end
			ST_SDIV: begin
				cmd.op = tpi_pkg::OP_DIVSTEP;
				cnt_d  = cnt_q + 4'd1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_SMUL;
				end
			end
			ST_SMUL: begin
				cmd.op  = tpi_pkg::OP_IMUL;
				state_d = ST_SINT;
			end
			ST_SINT: begin
				cmd.op  = tpi_pkg::OP_INTERP;
				state_d = ST_SWND;
			end
			ST_SWND: begin
				cnt_d = '0;
				if (sts.wind_go) begin
					cmd.op  = tpi_pkg::OP_WSTART;
					state_d = ST_SWHI;
				end else begin
					state_d = ST_SFIN;
				end
			end
			ST_SWHI: begin
				cmd.op  = tpi_pkg::OP_WHI;
				state_d = ST_SWLO;
			end
			ST_SWLO: begin
				cmd.op  = tpi_pkg::OP_WLO;
				state_d = ST_SWINC;
			end
			ST_SWINC: begin
				cmd.op = tpi_pkg::OP_WINC;
				cnt_d  = cnt_q + 4'd1;
				state_d = (cnt_q == AXIS_LAST) ? ST_SWCOM : ST_SWHI;
			end
			ST_SWCOM: begin
				cmd.op  = tpi_pkg::OP_WCOM;
				state_d = ST_SFIN;
			end
			ST_SFIN: begin
				cmd.op  = tpi_pkg::OP_SFIN;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end
endmodule
`default_nettype wire

// ===== verif/timestamp_playout_interpolator_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module timestamp_playout_interpolator_tb;

	localparam int DEPTH = tpi_pkg::DEF_BUFFER_DEPTH;
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam longint INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint INT64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
	localparam int LONG_HOLD_AT = 300;   // result index where the long receiver hold starts
	localparam int LONG_HOLD_LEN = 600;  // cycles of that hold
	localparam int DRAIN_AT = 750;       // random item index where the sender waits for drain

	typedef struct {
		tpi_pkg::req_t item;
		bit   drain_first;
	} pending_t;

	logic clk;
	logic arst_n;

	tpi_chan #(.payload_t(tpi_pkg::req_t)) req_ch ();
	tpi_chan #(.payload_t(tpi_pkg::rsp_t)) rsp_ch ();

	timestamp_playout_interpolator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow of the block's state, updated as each item is accepted.
	logic [31:0] ring_id[DEPTH];
	logic [15:0] ring_grid[DEPTH];
	logic [47:0] ring_sim[DEPTH];
	logic [47:0] ring_rx[DEPTH];
	int unsigned oldest;
	int unsigned frames;
	bit target_held;
	logic [47:0] last_target;
	bit baseline_held;
	logic [47:0] last_interp;
	longint last_wind[3];
	longint disp_acc[3];

	pending_t stim_q[$];
	tpi_pkg::rsp_t expected_rsp_q[$];
	int errors;
	int n_push, n_push_ok, n_sample, n_sample_ok, n_rsp;
	bit quiet_tx, quiet_rx;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timeout guard: far above the slowest legal run.
	initial begin
		#8ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int unsigned ring_slot(int unsigned i);
		return (oldest + i) % DEPTH;
	endfunction

	// Truncating mean-wind step; drop it when the magnitude reaches 2^63.
	function automatic bit wind_step(longint s, logic [47:0] dt, output longint inc);
		logic [63:0] mag;
		logic [127:0] prod;
		mag = (s < 0) ? -s : s;
		prod = ({64'b0, mag} * {80'b0, dt}) >> 17;
		inc = 0;
		if (prod >= 128'h8000_0000_0000_0000)
			return 1'b0;
		inc = (s < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
		return 1'b1;
	endfunction

	function automatic bit sum_fits(longint acc, longint inc);
		if (inc > 0 && acc > INT64_MAX - inc)
			return 1'b0;
		if (inc < 0 && acc < INT64_MIN - inc)
			return 1'b0;
		return 1'b1;
	endfunction

	task automatic clear_stream();
		frames = 0;
		oldest = 0;
		target_held = 0;
		baseline_held = 0;
		last_wind = '{0, 0, 0};
	endtask

	// Work out the result of one accepted item and queue it.
	task automatic predict_playout(input tpi_pkg::req_t r);
		tpi_pkg::rsp_t o;
		bit cont, ok;
		int unsigned n, k, lo, up, pi, ci;
		logic [31:0] id_step;
		logic [63:0] dly, req_t_raw, tgt, pr, cr, iv, num, ps, cs, interp;
		logic [16:0] blend;
		longint wind_now[3], inc[3];
		o = '0;
		if (r.command == CMD_PUSH) begin
			n_push++;
			if (r.frame_valid) begin
				n_push_ok++;
				cont = r.continuous;
				if (frames > 0) begin
					n = ring_slot(frames - 1);
					id_step = r.frame_id - ring_id[n];
					cont = cont && r.grid_size == ring_grid[n] && r.sim_time > ring_sim[n] &&
						r.receive_time >= ring_rx[n] && id_step != 0 &&
						id_step < tpi_pkg::HALF_RANGE;
				end
				if (!cont)
					clear_stream();
				// Overrun: drop the oldest frame.
				if (frames >= DEPTH) begin
					if (target_held && last_target < ring_rx[ring_slot(1)])
						baseline_held = 0;
					oldest = ring_slot(1);
					frames = DEPTH - 1;
				end
				k = ring_slot(frames);
				ring_id[k] = r.frame_id;
				ring_grid[k] = r.grid_size;
				ring_sim[k] = r.sim_time;
				ring_rx[k] = r.receive_time;
				frames++;
				o.accepted = 1'b1;
			end
			expected_rsp_q.push_back(o);
			return;
		end
		n_sample++;
		o.disp_x = disp_acc[0];
		o.disp_y = disp_acc[1];
		o.disp_z = disp_acc[2];
		if (frames == 0) begin
			expected_rsp_q.push_back(o);
			return;
		end
		n_sample_ok++;
		dly = (r.playout_delay > 0) ? 64'(r.playout_delay) : 64'd0;
		req_t_raw = (r.now_time >= dly) ? r.now_time - dly : 64'd0;
		tgt = (target_held && last_target > req_t_raw) ? last_target : req_t_raw;
		last_target = tgt[47:0];
		target_held = 1;

		// Walk the lower bracket, batching frames of equal receipt time.
		lo = 0;
		while (lo + 1 < frames && (ring_rx[ring_slot(lo + 1)] <= tgt ||
				ring_rx[ring_slot(lo + 1)] == ring_rx[ring_slot(lo)]))
			lo++;
		up = lo;
		pi = ring_slot(lo);
		blend = '0;
		if (lo + 1 < frames && tgt > ring_rx[pi]) begin
			pr = ring_rx[pi];
			up = lo + 1;
			while (up + 1 < frames && ring_rx[ring_slot(up + 1)] == ring_rx[ring_slot(up)])
				up++;
			cr = ring_rx[ring_slot(up)];
			if (cr > pr) begin
				iv = cr - pr;
				num = tgt - pr;
				if (num >= iv)
					blend = tpi_pkg::ONE_Q16;
				else
					blend = 17'((num << 16) / iv);
			end
		end
		ci = ring_slot(up);
		ps = ring_sim[pi];
		cs = ring_sim[ci];
		if (blend >= tpi_pkg::ONE_Q16)
			interp = cs;
		else if (cs >= ps)
			interp = ps + (((cs - ps) * blend) >> 16);
		else
			interp = ps - (((ps - cs) * blend) >> 16);
		interp &= 64'(MAX48);

		wind_now[0] = longint'(r.wind_x);
		wind_now[1] = longint'(r.wind_y);
		wind_now[2] = longint'(r.wind_z);
		if (baseline_held && interp[47:0] > last_interp) begin
			ok = 1;
			for (int a = 0; a < 3; a++)
				ok &= wind_step(last_wind[a] + wind_now[a], interp[47:0] - last_interp, inc[a]);
			for (int a = 0; a < 3; a++)
				ok &= ok && sum_fits(disp_acc[a], inc[a]);
			// Skip all three axes if any would overflow.
			if (ok)
				for (int a = 0; a < 3; a++)
					disp_acc[a] += inc[a];
		end
		last_interp = interp[47:0];
		last_wind = wind_now;
		baseline_held = 1;

		o.accepted = 1'b1;
		o.prev_frame_id = ring_id[pi];
		o.next_frame_id = ring_id[ci];
		o.blend = blend;
		o.interp_sim_time = interp[47:0];
		o.disp_x = disp_acc[0];
		o.disp_y = disp_acc[1];
		o.disp_z = disp_acc[2];
		expected_rsp_q.push_back(o);
	endtask

	// Sender: offer queued items, idle between them, hold for drain where marked.
	int tx_gap;
	int tx_count;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predict_playout(req_ch.data);
				tx_count++;
				if (tx_count % 120 == 0)
					quiet_tx = ~quiet_tx;
			end
			if (req_ch.valid && !req_ch.ready) begin
				// hold the offered item
			end else if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (stim_q.size() > 0 &&
					!(stim_q[0].drain_first && expected_rsp_q.size() > 0)) begin
				req_ch.data <= stim_q.pop_front().item;
				req_ch.valid <= 1'b1;
				tx_gap <= quiet_tx ? 0 : $urandom_range(0, 14);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Receiver: compare each result with the oldest expectation, stall at random.
	int rx_hold;
	int hold_draw;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_hold <= 0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			tpi_pkg::rsp_t e;
			tpi_pkg::rsp_t a;
			a = rsp_ch.data;
			n_rsp++;
			if (expected_rsp_q.size() == 0) begin
				$error("unexpected result item");
				errors++;
			end else begin
				e = expected_rsp_q.pop_front();
				check_field("accepted", 64'(e.accepted), 64'(a.accepted));
				check_field("prev_frame_id", 64'(e.prev_frame_id), 64'(a.prev_frame_id));
				check_field("next_frame_id", 64'(e.next_frame_id), 64'(a.next_frame_id));
				check_field("blend", 64'(e.blend), 64'(a.blend));
				check_field("interp_sim_time", 64'(e.interp_sim_time), 64'(a.interp_sim_time));
				check_field("disp_x", e.disp_x, a.disp_x);
				check_field("disp_y", e.disp_y, a.disp_y);
				check_field("disp_z", e.disp_z, a.disp_z);
			end
			if (n_rsp % 150 == 0)
				quiet_rx = ~quiet_rx;
			// Long hold-off so the block backs up and stalls its input.
			if (n_rsp == LONG_HOLD_AT)
				hold_draw = LONG_HOLD_LEN;
			else
				hold_draw = quiet_rx ? 0 : $urandom_range(0, 14);
			rx_hold <= hold_draw;
			rsp_ch.ready <= (hold_draw == 0);
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			rsp_ch.ready <= (rx_hold == 1);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	function automatic tpi_pkg::req_t noise_item();
		logic [351:0] raw;
		tpi_pkg::req_t r;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(tpi_pkg::req_t)-1:0];
		return r;
	endfunction

	function automatic tpi_pkg::req_t push_item(bit fv, bit cont, logic [31:0] id,
			logic [15:0] grid, logic [47:0] st, logic [47:0] rt);
		tpi_pkg::req_t r;
		r = noise_item();
		r.command = CMD_PUSH;
		r.frame_valid = fv;
		r.continuous = cont;
		r.frame_id = id;
		r.grid_size = grid;
		r.sim_time = st;
		r.receive_time = rt;
		return r;
	endfunction

	function automatic tpi_pkg::req_t sample_item(logic [47:0] now, logic [31:0] dly,
			logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
		tpi_pkg::req_t r;
		r = noise_item();
		r.command = CMD_SAMPLE;
		r.now_time = now;
		r.playout_delay = dly;
		r.wind_x = wx;
		r.wind_y = wy;
		r.wind_z = wz;
		return r;
	endfunction

	task automatic queue_item(tpi_pkg::req_t r, bit drain_first = 0);
		pending_t p;
		p.item = r;
		p.drain_first = drain_first;
		stim_q.push_back(p);
	endtask

	// Stimulus.
	initial begin
		logic [31:0] g_id;
		logic [15:0] g_grid;
		logic [47:0] g_sim, g_rx, now;
		logic [31:0] dly, w[3];
		int pick;
		tpi_pkg::req_t r;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		errors = 0;
		quiet_tx = 0;
		quiet_rx = 0;
		tx_count = 0;
		ring_id = '{default: '0};
		ring_grid = '{default: '0};
		ring_sim = '{default: '0};
		ring_rx = '{default: '0};
		clear_stream();
		last_target = '0;
		last_interp = '0;
		disp_acc = '{0, 0, 0};

		// Directed: empty sample, rejected push, id wrap, batching, extremes, overflow.
		queue_item(sample_item(MAX48, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '1));
		queue_item(push_item(0, 1, '1, '1, MAX48, MAX48));
		queue_item(push_item(1, 0, 32'hFFFF_FFFF, 16'hFFFF, 48'h0, 48'h0));
		queue_item(push_item(1, 1, 32'h0, 16'hFFFF, 48'h1_0000, 48'h1_0000));
		queue_item(push_item(1, 1, 32'h7FFF_FFFF, 16'hFFFF, 48'h2_0000, 48'h1_0000));
		queue_item(sample_item(48'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
		queue_item(push_item(1, 1, 32'h8000_0000, 16'hFFFF, MAX48, 48'h3_0000));
		queue_item(sample_item(48'h1_8000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
		queue_item(sample_item(48'h2_8000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
		queue_item(sample_item(MAX48, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1));
		queue_item(sample_item(48'h0, 32'h0, '0, '0, '0));
		// Id jump of half the range breaks the stream.
		queue_item(push_item(1, 1, 32'h0, 16'hFFFF, MAX48, MAX48));
		queue_item(push_item(1, 1, 32'h1, 16'h0, 48'h10, 48'h10));
		for (int i = 0; i < 9; i++)
			queue_item(push_item(1, 1, 32'(i + 2), 16'h0, 48'h10 + 48'(i + 1) * 48'h8000,
				48'h10 + 48'(i / 2) * 48'h4000));
		queue_item(sample_item(48'h8000, 32'h0, 32'h1_0000, 32'hFFFF_0000, 32'h0));
		queue_item(sample_item(48'h1_0000, 32'h4000, 32'h1_0000, 32'hFFFF_0000, 32'h0));
		queue_item(push_item(1, 0, 32'h20, 16'h0, 48'h8_0000, 48'h8_0000));

		// Random: mostly well-formed streams with random content.
		g_id = $urandom;
		g_grid = $urandom;
		g_sim = 48'h10_0000;
		g_rx = 48'h10_0000;
		for (int i = 0; i < 1500; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				r = noise_item();
			end else if (pick < 50) begin
				if ($urandom_range(0, 29) == 0) begin
					// start a fresh stream
					g_id = $urandom;
					g_grid = $urandom;
					g_sim = {16'h0, $urandom} & 48'h0_FFFF_FFFF;
					g_rx = {16'h0, $urandom} & 48'h0_FFFF_FFFF;
					r = push_item($urandom_range(0, 19) != 0, $urandom_range(0, 1), g_id, g_grid,
						g_sim, g_rx);
				end else begin
					g_id += $urandom_range(1, 3);
					g_sim += $urandom_range(1, 32'h2_0000);
					if ($urandom_range(0, 3) != 0)
						g_rx += $urandom_range(0, 32'h2_0000);
					r = push_item($urandom_range(0, 19) != 0, $urandom_range(0, 24) != 0, g_id,
						g_grid, g_sim, g_rx);
				end
			end else begin
				case ($urandom_range(0, 9))
					0: dly = $urandom;
					1: dly = 32'h8000_0000 | $urandom;
					default: dly = $urandom_range(0, 32'h4_0000);
				endcase
				now = g_rx + 48'(dly[31] ? 32'h0 : dly) - 48'($urandom_range(0, 32'h10_0000));
				for (int a = 0; a < 3; a++)
					w[a] = ($urandom_range(0, 7) == 0) ? $urandom :
						32'($signed($urandom_range(0, 32'hA_0000)) - 32'sh5_0000);
				r = sample_item(now, dly, w[0], w[1], w[2]);
			end
			queue_item(r, i == DRAIN_AT);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (stim_q.size() == 0 && !req_ch.valid);
		wait (expected_rsp_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d pushes (%0d valid) and %0d samples (%0d with frames)",
			n_push, n_push_ok, n_sample, n_sample_ok);
		$display("Checked %0d result items with random idling and a long receiver stall", n_rsp);
		if (errors == 0 && expected_rsp_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
